// ===== rtl/iidl_pkg.sv =====
// Package for the indexed insert/delete list: command codes, status codes and cell control.
`default_nettype none

package iidl_pkg;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_DELETE = 2'd3
  } iidl_cmd_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int DataW  = 32;
  localparam int FieldW = 9;
  localparam int Fanin  = 16;
  localparam int FaninW = 4;

  // Control broadcast to every cell for the cycle in which a command is applied.
  typedef struct packed {
    logic wr;
    logic ins;
    logic del;
  } iidl_ctl_t;

  // Number of registered sixteen-way OR levels needed to reduce n leaves to one.
  function automatic int tree_levels(input int n);
    int bits;
    bits = $clog2(n);
    return (bits + FaninW - 1) / FaninW;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/iidl_cell.sv =====
// One storage cell of the list: holds one element and shifts to or from its neighbours.
`default_nettype none

module iidl_cell #(
  parameter int Idx = 0,
  parameter int CW  = 9
) (
  input  logic                     clk_i,
  input  iidl_pkg::iidl_ctl_t      ctl_i,
  input  logic [CW-1:0]            pos_i,
  input  logic [iidl_pkg::DataW-1:0] value_i,
  input  logic [iidl_pkg::DataW-1:0] left_i,
  input  logic [iidl_pkg::DataW-1:0] right_i,
  output logic [iidl_pkg::DataW-1:0] data_o,
  output logic [iidl_pkg::DataW-1:0] sel_o
);
  import iidl_pkg::*;

  localparam logic [CW-1:0] MyIdx = CW'(Idx);

  logic [DataW-1:0] data_q;
  logic [DataW-1:0] data_d;
  logic             hit;
  logic             above;

  assign hit   = (pos_i == MyIdx);
  assign above = (MyIdx > pos_i);

  always_comb begin
    data_d = data_q;
    if (ctl_i.wr && hit) begin
      data_d = value_i;
    end else if (ctl_i.ins) begin
      if (hit) begin
        data_d = value_i;
      end else if (above) begin
        data_d = left_i;
      end
    end else if (ctl_i.del && (hit || above)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign sel_o  = hit ? data_q : '0;

endmodule

`default_nettype wire

// ===== rtl/iidl_or_tree.sv =====
// Registered sixteen-way OR tree that gathers the one selected cell value.
`default_nettype none

module iidl_or_tree #(
  parameter int N = 256
) (
  input  logic                       clk_i,
  input  logic [iidl_pkg::DataW-1:0] leaf_i [N],
  output logic [iidl_pkg::DataW-1:0] root_o
);
  import iidl_pkg::*;

  localparam int Levels = tree_levels(N);
  localparam int Padded = 1 << (FaninW * Levels);

  // Index of the first node of level l in the flat node array; level l has
  // Padded >> (FaninW * (l + 1)) nodes.
  function automatic int lvl_base(input int l);
    int s;
    s = 0;
    for (int k = 0; k < l; k++) begin
      s = s + (Padded >> (FaninW * (k + 1)));
    end
    return s;
  endfunction

  localparam int Nodes = lvl_base(Levels);

  logic [DataW-1:0] leaf   [Padded];
  logic [DataW-1:0] node_q [Nodes];

  for (genvar k = 0; k < Padded; k++) begin : g_leaf
    if (k < N) begin : g_real
      assign leaf[k] = leaf_i[k];
    end else begin : g_pad
      assign leaf[k] = '0;
    end
  end

  for (genvar l = 0; l < Levels; l++) begin : g_lvl
    localparam int Base = lvl_base(l);
    localparam int Cnt  = Padded >> (FaninW * (l + 1));
    localparam int Prev = (l > 0) ? lvl_base((l > 0) ? l - 1 : 0) : 0;
    for (genvar j = 0; j < Cnt; j++) begin : g_node
      logic [DataW-1:0] acc;
      if (l == 0) begin : g_first
        always_comb begin
          acc = '0;
          for (int m = 0; m < Fanin; m++) begin
            acc = acc | leaf[j * Fanin + m];
          end
        end
      end else begin : g_upper
        always_comb begin
          acc = '0;
          for (int m = 0; m < Fanin; m++) begin
            acc = acc | node_q[Prev + j * Fanin + m];
          end
        end
      end
      always_ff @(posedge clk_i) begin
        node_q[Base + j] <= acc;
      end
    end
  end

  assign root_o = node_q[Nodes-1];

endmodule

`default_nettype wire

// ===== rtl/indexed_insert_delete_list_core.sv =====
// Top level of the indexed insert/delete list: command decode, count and the row of cells.
//
//  Channel  Signals                                   Dir  Content
//  in       in_valid_i, in_ready_o                    in   command_i, position_i, value_i
//  out      out_valid_o, out_ready_i                  out  read_value_o, status_o, count_o
//
// One item is handled at a time. Write, insert, delete and any failed command give their
// result one cycle after acceptance; the cells shift or load in the cycle after that.
// A successful read takes tree_levels(CAPACITY) + 1 cycles, set by the registered OR tree
// that gathers the addressed cell (two levels at 256 entries).
// Reset clears the count and all handshake state; the cell contents are left as they are.
// A new item is taken only once the previous result has been taken.
`default_nettype none

module indexed_insert_delete_list_core #(
  parameter int CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [8:0]  position_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_value_o,
  output logic [1:0]  status_o,
  output logic [8:0]  count_o
);
  import iidl_pkg::*;

  localparam int CW     = ($clog2(CAPACITY + 1) > FieldW) ? $clog2(CAPACITY + 1) : FieldW;
  localparam int Levels = tree_levels(CAPACITY);
  localparam int TW     = $clog2(Levels + 1);
  localparam logic [CW-1:0] Cap = CW'(CAPACITY);

  logic [CW-1:0]     count_q;
  logic [CW-1:0]     count_d;
  logic              out_valid_q;
  logic [TW-1:0]     wait_q;
  logic              exec_q;
  logic [CW-1:0]     pos_q;
  logic [DataW-1:0]  value_q;
  iidl_cmd_e         cmd_q;
  logic [1:0]        status_q;
  logic [1:0]        status_d;
  logic [FieldW-1:0] count_out_q;
  logic              rd_ok_q;

  logic              accept;
  iidl_cmd_e         cmd;
  logic [CW-1:0]     pos_ext;
  logic              ok;
  iidl_ctl_t         ctl;
  logic [DataW-1:0]  tree_root;

  logic [DataW-1:0]  cell_data [CAPACITY];
  logic [DataW-1:0]  cell_sel  [CAPACITY];

  assign in_ready_o = !out_valid_q && !exec_q && (wait_q == '0);
  assign accept     = in_valid_i && in_ready_o;
  assign cmd        = iidl_cmd_e'(command_i);
  assign pos_ext    = CW'(position_i);

  always_comb begin
    status_d = ST_OK;
    count_d  = count_q;
    case (cmd)
      CMD_INSERT: begin
        if (pos_ext > count_q) begin
          status_d = ST_RANGE;
        end else if (count_q >= Cap) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      CMD_DELETE: begin
        if (pos_ext >= count_q) begin
          status_d = ST_RANGE;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (pos_ext >= count_q) begin
          status_d = ST_RANGE;
        end
      end
      default: begin
        status_d = ST_RANGE;
      end
    endcase
  end

  assign ok = (status_d == ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      wait_q      <= '0;
      exec_q      <= 1'b0;
    end else begin
      exec_q <= accept && ok && (cmd != CMD_READ);
      if (accept) begin
        count_q <= count_d;
        if (ok && (cmd == CMD_READ)) begin
          wait_q <= TW'(Levels);
        end else begin
          out_valid_q <= 1'b1;
        end
      end else begin
        if (wait_q != '0) begin
          wait_q <= wait_q - TW'(1);
          if (wait_q == TW'(1)) begin
            out_valid_q <= 1'b1;
          end
        end
        if (out_valid_q && out_ready_i) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q       <= pos_ext;
      value_q     <= value_i;
      cmd_q       <= cmd;
      status_q    <= status_d;
      count_out_q <= count_d[FieldW-1:0];
      rd_ok_q     <= ok && (cmd == CMD_READ);
    end
  end

  assign ctl.wr  = exec_q && (cmd_q == CMD_WRITE);
  assign ctl.ins = exec_q && (cmd_q == CMD_INSERT);
  assign ctl.del = exec_q && (cmd_q == CMD_DELETE);

  // Each cell takes from its lower neighbour on insert and from its upper one on delete.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] left;
    logic [DataW-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_data[(i > 0) ? i - 1 : 0];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_data[(i < CAPACITY - 1) ? i + 1 : i];
    end
    iidl_cell #(
      .Idx (i),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .pos_i   (pos_q),
      .value_i (value_q),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .sel_o   (cell_sel[i])
    );
  end

  iidl_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (cell_sel),
    .root_o (tree_root)
  );

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rd_ok_q ? tree_root : '0;
  assign status_o     = status_q;
  assign count_o      = count_out_q;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the indexed insert/delete list core.
`timescale 1ns / 1ps

module tb;

  import iidl_pkg::*;

  localparam int unsigned LIST_DEPTH = 256;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned TAIL_CYCLES = 8;

  typedef struct {
    iidl_cmd_e   cmd;
    logic [8:0]  pos;
    logic [31:0] val;
    int unsigned gap;
    bit          hold;
  } list_op_t;

  typedef struct {
    logic [31:0] rd;
    logic [1:0]  st;
    logic [8:0]  cnt;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  iidl_cmd_e   command = CMD_READ;
  logic [8:0]  position = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_value;
  logic [1:0]  status;
  logic [8:0]  out_count;

  // Mirror of the list held by the block.
  logic [31:0] cells [0:LIST_DEPTH-1];
  int unsigned list_len = 0;

  list_op_t     op_queue [$];
  list_result_t awaiting_results [$];

  int unsigned sent_cnt = 0;
  int unsigned done_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned range_hits = 0;
  int unsigned full_hits = 0;
  int unsigned ok_by_cmd [4] = '{0, 0, 0, 0};

  // Generator-side view of the count, used to shape positions.
  int unsigned gen_len = 0;
  int unsigned gen_items = 0;
  bit          gen_calm = 1'b0;

  int unsigned recv_stall = 0;
  bit          recv_calm = 1'b0;

  indexed_insert_delete_list_core #(
    .CAPACITY(LIST_DEPTH)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .command_i   (command),
    .position_i  (position),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .read_value_o(read_value),
    .status_o    (status),
    .count_o     (out_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 65) return 0;
    else if (r < 90) return $urandom_range(3, 1);
    else if (r < 97) return $urandom_range(12, 4);
    else return $urandom_range(50, 20);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9, 0))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Applies one command to the mirror and queues the result it must give.
  task automatic list_apply(input iidl_cmd_e cmd, input logic [8:0] pos,
                            input logic [31:0] val);
    list_result_t r;
    int unsigned i;
    r.rd = '0;
    r.st = ST_OK;
    case (cmd)
      CMD_READ: begin
        if (pos < list_len) r.rd = cells[pos];
        else r.st = ST_RANGE;
      end
      CMD_WRITE: begin
        if (pos < list_len) cells[pos] = val;
        else r.st = ST_RANGE;
      end
      CMD_INSERT: begin
        if (pos > list_len) begin
          r.st = ST_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          for (i = list_len; i > pos; i--) cells[i] = cells[i-1];
          cells[pos] = val;
          list_len++;
        end
      end
      default: begin
        if (pos < list_len) begin
          for (i = pos; i + 1 < list_len; i++) cells[i] = cells[i+1];
          cells[list_len-1] = '0;
          list_len--;
        end else begin
          r.st = ST_RANGE;
        end
      end
    endcase
    r.cnt = list_len[8:0];
    if (r.st == ST_RANGE) range_hits++;
    else if (r.st == ST_FULL) full_hits++;
    else ok_by_cmd[cmd]++;
    awaiting_results.push_back(r);
  endtask

  task automatic add_op(input iidl_cmd_e c, input int unsigned p, input logic [31:0] v);
    list_op_t o;
    o.cmd = c;
    o.pos = p[8:0];
    o.val = v;
    o.gap = gen_calm ? 0 : idle_len();
    o.hold = 1'b0;
    op_queue.push_back(o);
    gen_items++;
    if (c == CMD_INSERT && p <= gen_len && gen_len < LIST_DEPTH) gen_len++;
    else if (c == CMD_DELETE && p < gen_len) gen_len--;
  endtask

  // A pause in sending until every outstanding result has been taken.
  task automatic add_hold();
    list_op_t o;
    o.cmd = CMD_READ;
    o.pos = '0;
    o.val = '0;
    o.gap = 0;
    o.hold = 1'b1;
    op_queue.push_back(o);
  endtask

  // grow_pct is the share of inserts; deletes take the rest of sixty percent.
  task automatic add_random(input int unsigned grow_pct);
    int unsigned r;
    int unsigned pick;
    int unsigned lo;
    int unsigned p;
    iidl_cmd_e c;
    r = $urandom_range(99, 0);
    pick = $urandom_range(99, 0);
    if (pick < grow_pct) c = CMD_INSERT;
    else if (pick < 60) c = CMD_DELETE;
    else if (pick < 85) c = CMD_READ;
    else c = CMD_WRITE;
    if (gen_len == 0 && c != CMD_INSERT && $urandom_range(9, 0) < 7) c = CMD_INSERT;
    lo = (c == CMD_INSERT) ? gen_len + 1 : gen_len;
    if (r < 7 || lo == 0) p = $urandom_range(511, lo);
    else if (r < 22) p = 0;
    else if (r < 37) p = lo - 1;
    else p = $urandom_range(lo - 1, 0);
    add_op(c, p, pick_value());
  endtask

  // Driver: the head of the queue goes out once its idle gap has run down.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      command  <= CMD_READ;
      position <= '0;
      value    <= '0;
    end else begin
      if (in_valid && in_ready) begin
        list_apply(command, position, value);
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (op_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (op_queue[0].hold) begin
          in_valid <= 1'b0;
          if (done_cnt == sent_cnt) void'(op_queue.pop_front());
        end else if (op_queue[0].gap != 0) begin
          in_valid <= 1'b0;
          op_queue[0].gap = op_queue[0].gap - 1;
        end else begin
          command  <= op_queue[0].cmd;
          position <= op_queue[0].pos;
          value    <= op_queue[0].val;
          in_valid <= 1'b1;
          void'(op_queue.pop_front());
        end
      end
    end
  end

  // Monitor: takes results with random back-pressure and checks each one.
  always @(posedge clk or negedge rst_n) begin
    list_result_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaiting_results.size() == 0) begin
          $error("result with no command outstanding: read_value %h status %0d count %0d",
                 read_value, status, out_count);
          err_cnt++;
        end else begin
          exp_r = awaiting_results.pop_front();
          if (read_value !== exp_r.rd) begin
            $error("read_value: expected %h, got %h", exp_r.rd, read_value);
            err_cnt++;
          end
          if (status !== exp_r.st) begin
            $error("status: expected %0d, got %0d", exp_r.st, status);
            err_cnt++;
          end
          if (out_count !== exp_r.cnt) begin
            $error("count: expected %0d, got %0d", exp_r.cnt, out_count);
            err_cnt++;
          end
          done_cnt <= done_cnt + 1;
        end
      end
      if ($urandom_range(399, 0) == 0) recv_calm = ~recv_calm;
      if (recv_stall != 0) begin
        recv_stall = recv_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!recv_calm) recv_stall = idle_len();
      end
    end
  end

  initial begin
    int unsigned cycles;
    int unsigned phase_no;
    int unsigned target;

    // Empty list: every access is out of range.
    add_op(CMD_READ, 0, 32'h1111_1111);
    add_op(CMD_WRITE, 0, 32'h2222_2222);
    add_op(CMD_DELETE, 0, '0);
    add_op(CMD_INSERT, 1, 32'h3333_3333);
    add_op(CMD_INSERT, 511, 32'h4444_4444);
    // Build a short list at the front, the middle and the end.
    add_op(CMD_INSERT, 0, 32'h8000_0000);
    add_op(CMD_INSERT, 1, 32'h7FFF_FFFF);
    add_op(CMD_INSERT, 0, 32'hFFFF_FFFF);
    add_op(CMD_INSERT, 1, 32'h0000_0000);
    add_op(CMD_INSERT, 4, 32'h1234_5678);
    add_op(CMD_READ, 0, '0);
    add_op(CMD_READ, 4, '0);
    add_op(CMD_READ, 5, '0);
    add_op(CMD_WRITE, 2, 32'hA5A5_A5A5);
    add_op(CMD_WRITE, 5, 32'h5A5A_5A5A);
    add_op(CMD_READ, 2, '0);
    // Remove the last, the first and a middle element.
    add_op(CMD_DELETE, 4, '0);
    add_op(CMD_DELETE, 0, '0);
    add_op(CMD_DELETE, 1, '0);
    add_op(CMD_READ, 0, '0);
    add_op(CMD_READ, 1, '0);
    add_op(CMD_DELETE, 2, '0);
    add_hold();

    target = gen_items + RANDOM_ITEMS;
    phase_no = 0;
    while (gen_items < target) begin
      gen_calm = ($urandom_range(3, 0) == 0);
      case ((phase_no == 2) ? 3 : $urandom_range(4, 0))
        0: repeat ($urandom_range(80, 30)) add_random(50);
        1: repeat ($urandom_range(80, 30)) add_random(10);
        2: repeat ($urandom_range(80, 30)) add_random(30);
        3: begin
          // Fill to capacity, then keep working against the full list.
          while (gen_len < LIST_DEPTH) add_random(100);
          add_op(CMD_INSERT, LIST_DEPTH, pick_value());
          add_op(CMD_INSERT, LIST_DEPTH + 1, pick_value());
          repeat (12) add_random(45);
        end
        default: begin
          while (gen_len != 0) add_random(0);
          repeat (4) add_random(30);
        end
      endcase
      if ($urandom_range(2, 0) == 0) add_hold();
      phase_no++;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    cycles = 0;
    while (!(op_queue.size() == 0 && !in_valid && done_cnt == sent_cnt)
           && cycles < CYCLE_LIMIT) begin
      @(negedge clk);
      cycles++;
    end

    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycles, awaiting_results.size());
      $display("tb: errors");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      $display("Covered %0d commands: %0d read, %0d write, %0d insert, %0d delete succeeded",
               sent_cnt, ok_by_cmd[CMD_READ], ok_by_cmd[CMD_WRITE],
               ok_by_cmd[CMD_INSERT], ok_by_cmd[CMD_DELETE]);
      $display("%0d index errors and %0d full refusals; %0d results checked",
               range_hits, full_hits, done_cnt);
      if (err_cnt == 0 && awaiting_results.size() == 0) begin
        $display("tb: clean");
      end else begin
        $display("tb: errors");
      end
    end
    $finish;
  end

endmodule

// ===== indexed_insert_delete_list_core.f =====
rtl/iidl_pkg.sv
rtl/iidl_cell.sv
rtl/iidl_or_tree.sv
rtl/indexed_insert_delete_list_core.sv
verif/tb.sv
